FILE: hdl/cstv_pkg.sv
// ----------------------------------------------------------------------------
// cstv_pkg: shared constants for the cube-to-sphere vertex map
// Widths, pipeline depths of the divide and root units, face vector tables.
// ----------------------------------------------------------------------------
package cstv_pkg;

  // Field widths
  localparam int MAX_DIVISIONS = 256;
  localparam int DIVS_W        = 9;
  localparam int RADIUS_W      = 31;
  localparam int FACE_W        = 3;
  localparam int IDX_W         = 9;
  localparam int POS_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 31;

  // Fixed point
  localparam int Q_FRAC     = 16;
  localparam int Q_ONE      = 65536;
  localparam int ROUND_HALF = 32768;
  localparam int MAG_W      = 17;   // magnitude of a Q2.16 value, up to 1.0 and a bit
  localparam int OFF_W      = 18;   // cube offset, up to 2.0

  // floor(x/3) = (x*43691) >> 17 for x below 2^17
  localparam int THIRD_RECIP = 43691;
  localparam int THIRD_SHIFT = 17;

  // Pipelined restoring divider
  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 18;
  localparam int DIV_QUO_W = 33;
  localparam int DIV_BPS   = 3;
  localparam int DIV_STG   = DIV_QUO_W / DIV_BPS;

  // Pipelined square root
  localparam int SQ_IN_W  = 36;
  localparam int SQ_RT_W  = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_RT_W + 2;
  localparam int SQ_BPS   = 2;
  localparam int SQ_STG   = SQ_RT_W / SQ_BPS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 1'b1;

  // Face vectors: entries are -1, 0 or +1
  typedef logic signed [1:0] trit_t;
  typedef trit_t [0:2] tvec_t;

  localparam trit_t T_NEG  = 2'sb11;
  localparam trit_t T_ZERO = 2'sb00;
  localparam trit_t T_POS  = 2'sb01;

  localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;

  localparam tvec_t ORG_TAB [0:5] = '{
    '{T_NEG, T_NEG, T_NEG}, '{T_POS, T_NEG, T_NEG}, '{T_POS, T_NEG, T_POS},
    '{T_NEG, T_NEG, T_POS}, '{T_NEG, T_POS, T_NEG}, '{T_NEG, T_NEG, T_POS}
  };
  localparam tvec_t RGT_TAB [0:5] = '{
    '{T_POS, T_ZERO, T_ZERO}, '{T_ZERO, T_ZERO, T_POS}, '{T_NEG, T_ZERO, T_ZERO},
    '{T_ZERO, T_ZERO, T_NEG}, '{T_POS, T_ZERO, T_ZERO}, '{T_POS, T_ZERO, T_ZERO}
  };
  localparam tvec_t UPV_TAB [0:5] = '{
    '{T_ZERO, T_POS, T_ZERO}, '{T_ZERO, T_POS, T_ZERO}, '{T_ZERO, T_POS, T_ZERO},
    '{T_ZERO, T_POS, T_ZERO}, '{T_ZERO, T_ZERO, T_POS}, '{T_ZERO, T_ZERO, T_NEG}
  };

endpackage

FILE: hdl/cstv_div_pipe.sv
// ----------------------------------------------------------------------------
// cstv_div_pipe: pipelined unsigned restoring divider
// Three quotient bits per stage; flags a quotient too wide for the result.
// ----------------------------------------------------------------------------
module cstv_div_pipe import cstv_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_QUO_W-1:0] quo_o,
  output logic                 ovf_o
);

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_QUO_W-1:0] nlo;
    logic [DIV_QUO_W-1:0] quo;
    logic [DIV_DEN_W-1:0] den;
    logic                 ovf;
  } dstg_t;

  dstg_t stg_r   [DIV_STG];
  dstg_t stg_nxt [DIV_STG];

  // Quotient bits per stage, high part of the numerator seeds the remainder
  always_comb begin
    dstg_t                cur;
    logic [DIV_DEN_W:0]   w;
    for (int j = 0; j < DIV_STG; j++) begin
      if (j == 0) begin
        cur.rem = DIV_DEN_W'(num_i >> DIV_QUO_W);
        cur.nlo = num_i[DIV_QUO_W-1:0];
        cur.quo = '0;
        cur.den = den_i;
        cur.ovf = (num_i >> DIV_QUO_W) >= DIV_NUM_W'(den_i);
      end else begin
        cur = stg_r[j-1];
      end
      for (int b = 0; b < DIV_BPS; b++) begin
        w       = {cur.rem, cur.nlo[DIV_QUO_W-1]};
        cur.nlo = {cur.nlo[DIV_QUO_W-2:0], 1'b0};
        if (w >= {1'b0, cur.den}) begin
          cur.rem = DIV_DEN_W'(w - {1'b0, cur.den});
          cur.quo = {cur.quo[DIV_QUO_W-2:0], 1'b1};
        end else begin
          cur.rem = w[DIV_DEN_W-1:0];
          cur.quo = {cur.quo[DIV_QUO_W-2:0], 1'b0};
        end
      end
      stg_nxt[j] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STG; j++) stg_r[j] <= stg_nxt[j];
    end
  end

  assign quo_o = stg_r[DIV_STG-1].quo;
  assign ovf_o = stg_r[DIV_STG-1].ovf;

endmodule

FILE: hdl/cstv_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// cstv_sqrt_pipe: pipelined integer square root
// Digit-by-digit floor root, two result bits per stage.
// ----------------------------------------------------------------------------
module cstv_sqrt_pipe import cstv_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [SQ_IN_W-1:0] rad_i,
  output logic [SQ_RT_W-1:0] root_o
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_RT_W-1:0]  root;
    logic [SQ_IN_W-1:0]  rest;
  } sstg_t;

  sstg_t stg_r   [SQ_STG];
  sstg_t stg_nxt [SQ_STG];

  // Each step pulls two radicand bits and tries root*4+1
  always_comb begin
    sstg_t                cur;
    logic [SQ_REM_W+1:0]  w;
    logic [SQ_REM_W+1:0]  trial;
    for (int j = 0; j < SQ_STG; j++) begin
      if (j == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.rest = rad_i;
      end else begin
        cur = stg_r[j-1];
      end
      for (int b = 0; b < SQ_BPS; b++) begin
        w        = {cur.rem, cur.rest[SQ_IN_W-1 -: 2]};
        trial    = (SQ_REM_W+2)'({cur.root, 2'b01});
        cur.rest = {cur.rest[SQ_IN_W-3:0], 2'b00};
        if (w >= trial) begin
          cur.rem  = SQ_REM_W'(w - trial);
          cur.root = {cur.root[SQ_RT_W-2:0], 1'b1};
        end else begin
          cur.rem  = SQ_REM_W'(w);
          cur.root = {cur.root[SQ_RT_W-2:0], 1'b0};
        end
      end
      stg_nxt[j] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQ_STG; j++) stg_r[j] <= stg_nxt[j];
    end
  end

  assign root_o = stg_r[SQ_STG-1].root;

endmodule

FILE: hdl/cube_to_sphere_vertex_map_unit.sv
// An accepted input beat passes through all pipeline stages and the output register to out_valid.
// Throughput: one beat per cycle while the skid entry is empty; all stages, incl. the two
// 11-stage dividers and the two 9-stage root units, advance together and take a new item
// every cycle. A two-entry output buffer (head and skid) keeps intake going while a result
// waits, until the skid entry fills. Reset (synchronous, rst_n low) clears all valid bits
// and the output buffer and sets divisions to 8 and radius to 1.0.
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex_map_unit: grid point on a cube face to sphere vertex
// Cube point, per-axis spherify, normalize and scale to the radius.
// ----------------------------------------------------------------------------
module cube_to_sphere_vertex_map_unit import cstv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [FACE_W-1:0]            in_face,
  input  logic [IDX_W-1:0]             in_col,
  input  logic [IDX_W-1:0]             in_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [POS_W-1:0]      out_pos_x,
  output logic signed [POS_W-1:0]      out_pos_y,
  output logic signed [POS_W-1:0]      out_pos_z,
  output logic                         out_out_of_range,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB1_LEN = DIV_STG + 1;
  localparam int SB2_LEN = 5 + SQ_STG;
  localparam int SB3_LEN = 3 + SQ_STG;
  localparam int SB4_LEN = 1 + DIV_STG;
  localparam int NST     = SB1_LEN + SB2_LEN + SB3_LEN + SB4_LEN;
  localparam int P_W     = 20;
  localparam int T_W     = 11;

  localparam logic [DIV_QUO_W-1:0] LIM_POS = DIV_QUO_W'(33'h0_7FFF_FFFF);
  localparam logic [DIV_QUO_W-1:0] LIM_NEG = DIV_QUO_W'(33'h0_8000_0000);

  typedef struct packed {
    logic       oor;
    logic [2:0] tneg;
    logic [2:0] oneg;
  } cube_sb_t;

  typedef struct packed {
    logic                  oor;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } vec_sb_t;

  typedef struct packed {
    logic       oor;
    logic       lenz;
    logic [2:0] nneg;
  } out_sb_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic                  oor;
  } res_t;

  // Configuration registers
  logic [DIVS_W-1:0]   divisions_r;
  logic [RADIUS_W-1:0] radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisions_r <= DIVS_W'(8);
      radius_r    <= RADIUS_W'(Q_ONE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIVISIONS: divisions_r <= cfg_data[DIVS_W-1:0];
        CFG_RADIUS:    radius_r    <= cfg_data[RADIUS_W-1:0];
      endcase
    end
  end

  // Pipeline control: one advance for all stages, held while the skid entry is full
  logic             adv;
  logic [0:NST-1]   v_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  res_t             head_r;
  res_t             skid_r;
  res_t             res_nxt;
  logic             push;
  logic             pop;

  assign adv      = !skid_valid_r;
  assign in_ready = adv;
  assign push     = adv && v_r[NST-1];
  assign pop      = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {in_valid, v_r[0:NST-2]};
    end
  end

  // Stage 0: clamp config, table lookup, offset numerators
  logic [DIVS_W-1:0]    div_eff;
  logic [FACE_W-1:0]    face_c;
  logic [DIV_NUM_W-1:0] num1_nxt [3];
  cube_sb_t             sb1_nxt;

  function automatic logic signed [T_W-1:0] trit_mul(logic signed [T_W-1:0] a, trit_t s);
    logic signed [T_W-1:0] r;
    unique case (s)
      T_POS:   r = a;
      T_NEG:   r = -a;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    if (divisions_r == '0) div_eff = DIVS_W'(1);
    else if (divisions_r > DIVS_W'(MAX_DIVISIONS)) div_eff = DIVS_W'(MAX_DIVISIONS);
    else div_eff = divisions_r;
    face_c = (in_face > FACE_LAST) ? FACE_LAST : in_face;
  end

  always_comb begin
    logic signed [T_W-1:0] colx;
    logic signed [T_W-1:0] rowx;
    logic signed [T_W-1:0] t;
    logic signed [T_W-1:0] tabs;
    colx        = signed'({2'b00, in_col});
    rowx        = signed'({2'b00, in_row});
    sb1_nxt.oor = (in_col > div_eff) || (in_row > div_eff);
    for (int k = 0; k < 3; k++) begin
      t    = trit_mul(colx, RGT_TAB[face_c][k]) + trit_mul(rowx, UPV_TAB[face_c][k]);
      tabs = t[T_W-1] ? -t : t;
      sb1_nxt.tneg[k] = t[T_W-1];
      sb1_nxt.oneg[k] = (ORG_TAB[face_c][k] == T_NEG);
      num1_nxt[k] = DIV_NUM_W'({tabs[T_W-2:0], 17'b0}) + DIV_NUM_W'(div_eff >> 1);
    end
  end

  logic [DIV_NUM_W-1:0] num1_r [3];
  logic [DIV_DEN_W-1:0] den1_r;
  cube_sb_t             sb1_r [SB1_LEN];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) num1_r[k] <= num1_nxt[k];
      den1_r   <= DIV_DEN_W'(div_eff);
      sb1_r[0] <= sb1_nxt;
      for (int j = 1; j < SB1_LEN; j++) sb1_r[j] <= sb1_r[j-1];
    end
  end

  // Stages 1..11: offset = round(|t| * 2 / divisions)
  logic [DIV_QUO_W-1:0] quo1_c [3];
  logic                 ovf1_c [3];
  logic [SQ_RT_W-1:0]   root_c [3];
  logic [DIV_NUM_W-1:0] num2_r [3];
  logic [DIV_DEN_W-1:0] den2_r;
  logic [DIV_QUO_W-1:0] quo2_c [3];
  logic                 ovf2_c [3];
  logic [MAG_W-1:0]     rad_r  [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    cstv_div_pipe u_div_cube (
      .clk   (clk),
      .en    (adv),
      .num_i (num1_r[k]),
      .den_i (den1_r),
      .quo_o (quo1_c[k]),
      .ovf_o (ovf1_c[k])
    );
    cstv_sqrt_pipe u_sqrt_axis (
      .clk    (clk),
      .en     (adv),
      .rad_i  (SQ_IN_W'({rad_r[k], 16'b0})),
      .root_o (root_c[k])
    );
    cstv_div_pipe u_div_scale (
      .clk   (clk),
      .en    (adv),
      .num_i (num2_r[k]),
      .den_i (den2_r),
      .quo_o (quo2_c[k]),
      .ovf_o (ovf2_c[k])
    );
  end

  // Stage P: cube point, sign and magnitude
  vec_sb_t sb2_nxt;

  always_comb begin
    cube_sb_t              s;
    logic [OFF_W-1:0]      off;
    logic signed [P_W-1:0] offs;
    logic signed [P_W-1:0] base;
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] pabs;
    s           = sb1_r[SB1_LEN-1];
    sb2_nxt.oor = s.oor;
    for (int k = 0; k < 3; k++) begin
      off  = ovf1_c[k] ? '1 : quo1_c[k][OFF_W-1:0];
      offs = signed'(P_W'(off));
      if (s.tneg[k]) offs = -offs;
      base = signed'(P_W'(Q_ONE));
      if (s.oneg[k]) base = -base;
      p    = base + offs;
      pabs = p[P_W-1] ? -p : p;
      sb2_nxt.neg[k] = p[P_W-1];
      sb2_nxt.mag[k] = MAG_W'(unsigned'(pabs));
    end
  end

  vec_sb_t          sb2_r    [SB2_LEN];
  logic [MAG_W-1:0] sq_r     [3];
  logic [MAG_W-1:0] half_r   [3];
  logic [MAG_W-1:0] prod_r   [3];
  logic [MAG_W-1:0] half2_r  [3];
  logic [15:0]      third_r  [3];
  logic [MAG_W-1:0] sq_nxt   [3];
  logic [MAG_W-1:0] half_nxt [3];
  logic [MAG_W-1:0] prod_nxt [3];
  logic [15:0]      third_nxt[3];
  logic [MAG_W-1:0] rad_nxt  [3];

  // Stages SQ, H, T, R: squares, half sum and product, third, radicand
  always_comb begin
    logic [33:0]      pp;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [17:0]      pn;
    logic [33:0]      tm;
    logic [17:0]      rs;
    for (int k = 0; k < 3; k++) begin
      pp = 34'(sb2_r[0].mag[k]) * 34'(sb2_r[0].mag[k]);
      sq_nxt[k] = MAG_W'((pp + 34'(ROUND_HALF)) >> Q_FRAC);

      a = sq_r[(k + 1) % 3];
      b = sq_r[(k + 2) % 3];
      half_nxt[k] = MAG_W'((18'(a) + 18'(b) + 18'd1) >> 1);
      pp = 34'(a) * 34'(b);
      prod_nxt[k] = MAG_W'((pp + 34'(ROUND_HALF)) >> Q_FRAC);

      pn = 18'(prod_r[k]) + 18'd1;
      tm = 34'(pn) * 34'(THIRD_RECIP);
      third_nxt[k] = 16'(tm >> THIRD_SHIFT);

      rs = 18'(Q_ONE) + 18'(third_r[k]);
      rad_nxt[k] = (rs > 18'(half2_r[k])) ? MAG_W'(rs - 18'(half2_r[k])) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb2_r[0] <= sb2_nxt;
      for (int j = 1; j < SB2_LEN; j++) sb2_r[j] <= sb2_r[j-1];
      for (int k = 0; k < 3; k++) begin
        sq_r[k]    <= sq_nxt[k];
        half_r[k]  <= half_nxt[k];
        prod_r[k]  <= prod_nxt[k];
        half2_r[k] <= half_r[k];
        third_r[k] <= third_nxt[k];
        rad_r[k]   <= rad_nxt[k];
      end
    end
  end

  // Stages M, NS, SUM: spherified axes, their squares, squared length
  vec_sb_t          sb3_nxt;
  vec_sb_t          sb3_r [SB3_LEN];
  logic [33:0]      nsq_r   [3];
  logic [33:0]      nsq_nxt [3];
  logic [SQ_IN_W-1:0] sum_r;
  logic [SQ_RT_W-1:0] len_c;

  always_comb begin
    vec_sb_t     s;
    logic [35:0] mm;
    s           = sb2_r[SB2_LEN-1];
    sb3_nxt.oor = s.oor;
    sb3_nxt.neg = s.neg;
    for (int k = 0; k < 3; k++) begin
      mm = 36'(s.mag[k]) * 36'(root_c[k]);
      sb3_nxt.mag[k] = MAG_W'((mm + 36'(ROUND_HALF)) >> Q_FRAC);
      nsq_nxt[k] = 34'(sb3_r[0].mag[k]) * 34'(sb3_r[0].mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb3_r[0] <= sb3_nxt;
      for (int j = 1; j < SB3_LEN; j++) sb3_r[j] <= sb3_r[j-1];
      for (int k = 0; k < 3; k++) nsq_r[k] <= nsq_nxt[k];
      sum_r <= SQ_IN_W'(nsq_r[0]) + SQ_IN_W'(nsq_r[1]) + SQ_IN_W'(nsq_r[2]);
    end
  end

  cstv_sqrt_pipe u_sqrt_len (
    .clk    (clk),
    .en     (adv),
    .rad_i  (sum_r),
    .root_o (len_c)
  );

  // Stage V: scale numerators radius*|n| + len/2
  out_sb_t              sb4_nxt;
  out_sb_t              sb4_r [SB4_LEN];
  logic [DIV_NUM_W-1:0] num2_nxt [3];

  always_comb begin
    vec_sb_t s;
    s            = sb3_r[SB3_LEN-1];
    sb4_nxt.oor  = s.oor;
    sb4_nxt.nneg = s.neg;
    sb4_nxt.lenz = (len_c == '0);
    for (int k = 0; k < 3; k++) begin
      num2_nxt[k] = DIV_NUM_W'(48'(radius_r) * 48'(s.mag[k])) + DIV_NUM_W'(len_c >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) num2_r[k] <= num2_nxt[k];
      den2_r   <= DIV_DEN_W'(len_c);
      sb4_r[0] <= sb4_nxt;
      for (int j = 1; j < SB4_LEN; j++) sb4_r[j] <= sb4_r[j-1];
    end
  end

  // Final: saturate, apply sign, zero on out-of-range or zero length
  always_comb begin
    out_sb_t              s;
    logic [DIV_QUO_W-1:0] m;
    s           = sb4_r[SB4_LEN-1];
    res_nxt.oor = s.oor;
    for (int k = 0; k < 3; k++) begin
      if (s.nneg[k]) begin
        m = (ovf2_c[k] || quo2_c[k] > LIM_NEG) ? LIM_NEG : quo2_c[k];
        res_nxt.pos[k] = POS_W'(DIV_QUO_W'(0) - m);
      end else begin
        m = (ovf2_c[k] || quo2_c[k] > LIM_POS) ? LIM_POS : quo2_c[k];
        res_nxt.pos[k] = POS_W'(m);
      end
      if (s.oor || s.lenz) res_nxt.pos[k] = '0;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        if (!out_valid_r) out_valid_r <= 1'b1;
        else skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      head_r <= skid_r;
    end else if (push && (pop || !out_valid_r)) begin
      head_r <= res_nxt;
    end
    if (push && out_valid_r && !pop) skid_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = signed'(head_r.pos[0]);
  assign out_pos_y        = signed'(head_r.pos[1]);
  assign out_pos_z        = signed'(head_r.pos[2]);
  assign out_out_of_range = head_r.oor;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever filled behind a held head beat
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without a head beat");

  // A waiting skid entry survives a stalled cycle
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && out_valid_r))
    else $error("skid entry lost while stalled");

  // Out-of-range beats carry zero coordinates
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0))
    else $error("out-of-range beat with nonzero coordinates");
`endif

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for cube_to_sphere_vertex_map_unit
// Drives grid points through the valid/ready input with random gaps and
// stalls, predicts each vertex in fixed point, checks results in order, and
// rewrites divisions and radius between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb import cstv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 50;
  localparam int LIMIT     = 2000000;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
  } point_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    oor;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FACE_W-1:0] in_face = '0;
  logic [IDX_W-1:0] in_col = '0;
  logic [IDX_W-1:0] in_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cube_to_sphere_vertex_map_unit dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic [DIVS_W-1:0]   divs_reg = 9'd8;
  logic [RADIUS_W-1:0] radius_reg = 31'd65536;

  point_t  point_q[$];
  vertex_t vertex_q[$];
  int errors = 0;
  int n_checked = 0;
  int n_oor = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit run_done = 1'b0;

  // cfg request mailbox: set by the stimulus process, cleared by the driver
  bit cfg_req = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_req_idx;
  logic [CFG_DATA_W-1:0] cfg_req_data;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  // bend one cube axis toward the sphere using the other two squares
  function automatic longint bend_axis(longint p, longint unsigned a, longint unsigned b);
    longint unsigned half, prod, third, rad, root, m;
    half  = (a + b + 1) >> 1;
    prod  = (a * b + 32768) >> 16;
    third = (prod + 1) / 3;
    rad   = 65536 + third;
    rad   = rad > half ? rad - half : 0;
    root  = isqrt(rad << 16);
    m     = (magn(p) * root + 32768) >> 16;
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic vertex_t sphere_vertex(point_t pt);
    vertex_t v;
    longint unsigned dv, f, sq[3], sum, len, m, off;
    longint p[3], n[3], t;
    v = '0;
    dv = 64'(divs_reg);
    if (dv == 0) dv = 1;
    if (dv > MAX_DIVISIONS) dv = MAX_DIVISIONS;
    f = 64'(pt.face > FACE_LAST ? FACE_LAST : pt.face);
    if (pt.col > dv || pt.row > dv) begin
      v.oor = 1'b1;
      return v;
    end
    for (int k = 0; k < 3; k++) begin
      t = longint'(pt.col) * RGT_TAB[f][k] + longint'(pt.row) * UPV_TAB[f][k];
      off = (magn(t) * 131072 + dv / 2) / dv;
      p[k] = longint'(ORG_TAB[f][k]) * Q_ONE + (t < 0 ? -longint'(off) : longint'(off));
      sq[k] = (magn(p[k]) * magn(p[k]) + 32768) >> 16;
    end
    n[0] = bend_axis(p[0], sq[1], sq[2]);
    n[1] = bend_axis(p[1], sq[2], sq[0]);
    n[2] = bend_axis(p[2], sq[0], sq[1]);
    sum = 0;
    for (int k = 0; k < 3; k++) sum += magn(n[k]) * magn(n[k]);
    len = isqrt(sum);
    for (int k = 0; k < 3; k++) begin
      logic [31:0] r;
      r = '0;
      if (len != 0) begin
        m = (longint'(radius_reg) * magn(n[k]) + len / 2) / len;
        if (n[k] < 0) begin
          if (m > 64'h8000_0000) m = 64'h8000_0000;
          r = 32'(-m);
        end else begin
          if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
          r = 32'(m);
        end
      end
      case (k)
        0: v.x = r;
        1: v.y = r;
        default: v.z = r;
      endcase
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s at result %0d: got %0d, expected %0d", what, n_checked, got, want);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // input driver: one beat per pending point, with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        vertex_q = {vertex_q, sphere_vertex({in_face, in_col, in_row})};
        in_gap = gap_len();
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (point_q.size() > 0) begin
          point_t pt;
          pt = point_q.pop_front();
          in_valid <= 1'b1;
          in_face <= pt.face;
          in_col <= pt.col;
          in_row <= pt.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // config driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DIVISIONS) divs_reg <= cfg_data[DIVS_W-1:0];
        else radius_reg <= cfg_data[RADIUS_W-1:0];
        cfg_valid <= 1'b0;
        cfg_req <= 1'b0;
      end else if (cfg_req && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_req_idx;
        cfg_data <= cfg_req_data;
      end
    end
  end

  // result monitor with random stalls
  int out_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        vertex_t want;
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = vertex_q.pop_front();
          if (out_pos_x !== want.x) report_mismatch("pos_x", out_pos_x, want.x);
          if (out_pos_y !== want.y) report_mismatch("pos_y", out_pos_y, want.y);
          if (out_pos_z !== want.z) report_mismatch("pos_z", out_pos_z, want.z);
          if (out_out_of_range !== want.oor)
            report_mismatch("out_of_range", out_out_of_range, want.oor);
          if (want.oor) n_oor++;
          n_checked++;
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT && !run_done) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_req_idx = idx;
    cfg_req_data = data;
    cfg_req = 1'b1;
    while (cfg_req) @(posedge clk);
  endtask

  // queues settle by the falling edge, so the idle check sees every beat
  task automatic drain();
    while (point_q.size() > 0 || in_valid || vertex_q.size() > 0) @(negedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_point(point_t pt);
    point_q = {point_q, pt};
  endtask

  function automatic point_t rand_point(int dv, bit wild);
    point_t pt;
    int lim;
    lim = dv < 1 ? 1 : (dv > MAX_DIVISIONS ? MAX_DIVISIONS : dv);
    pt.face = FACE_W'($urandom_range(0, 5));
    pt.col = IDX_W'($urandom_range(0, lim));
    pt.row = IDX_W'($urandom_range(0, lim));
    if (wild) begin
      pt.face = FACE_W'($urandom_range(0, 7));
      pt.col = IDX_W'($urandom_range(0, 511));
      pt.row = IDX_W'($urandom_range(0, 511));
    end else if ($urandom_range(0, 9) == 0) begin
      pt.col = $urandom_range(0, 1) ? '0 : IDX_W'(lim);
    end
    return pt;
  endfunction

  // one phase: configure, run random points, drain
  task automatic phase(int dv, logic [30:0] rad, int count);
    write_reg(CFG_DIVISIONS, CFG_DATA_W'(dv));
    write_reg(CFG_RADIUS, rad);
    for (int i = 0; i < count; i++) queue_point(rand_point(dv, $urandom_range(0, 9) == 0));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default setup, two opposite corners of every face, faces six and seven, overrange
    for (int f = 0; f < 8; f++) begin
      queue_point('{face: f, col: 0, row: 0});
      queue_point('{face: f, col: 8, row: 8});
    end
    queue_point('{face: 0, col: 4, row: 4});
    queue_point('{face: 1, col: 9, row: 0});
    queue_point('{face: 2, col: 0, row: 9});
    queue_point('{face: 3, col: 511, row: 511});
    queue_point('{face: 4, col: 8, row: 0});
    drain();

    // zero divisions acts as one, large divisions saturate, extreme radii
    write_reg(CFG_DIVISIONS, 0);
    write_reg(CFG_RADIUS, 31'h7FFF_FFFF);
    queue_point('{face: 5, col: 1, row: 1});
    queue_point('{face: 2, col: 1, row: 2});
    queue_point('{face: 0, col: 1, row: 0});
    drain();
    write_reg(CFG_DIVISIONS, 9'h1FF);
    write_reg(CFG_RADIUS, 0);
    queue_point('{face: 1, col: 256, row: 128});
    queue_point('{face: 4, col: 257, row: 0});
    drain();

    // backpressure: receiver holds off while the sender keeps offering
    write_reg(CFG_DIVISIONS, 16);
    write_reg(CFG_RADIUS, 31'd65536);
    hold_off = 1'b1;
    for (int i = 0; i < 120; i++) queue_point(rand_point(16, 1'b0));
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // random phases across several settings
    phase(1, 31'd65536, 200);
    phase(256, 31'h7FFF_FFFF, 300);
    phase($urandom_range(2, 255), 31'($urandom_range(1, 31'h7FFF_FFFF)), 400);
    phase(8, 31'd1, 200);
    phase($urandom_range(2, 64), 31'd100 << 16, 500);
    phase($urandom_range(257, 511), 31'($urandom), 400);

    run_done = 1'b1;
    $display("Checked %0d vertices (%0d out of range) over several divisions/radius settings,",
             n_checked, n_oor);
    $display("with random gaps, stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: cube_to_sphere_vertex_map_unit.f
hdl/cstv_pkg.sv
hdl/cstv_div_pipe.sv
hdl/cstv_sqrt_pipe.sv
hdl/cube_to_sphere_vertex_map_unit.sv
bench/tb.sv
